// ----- hdl/mpe_pkg.sv -----
// Shared types, character codes and helpers for the MIME parameter extractor.
`default_nettype none

package mpe_pkg;

	localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
	localparam logic [7:0] CH_DQUOTE = 8'h22; // '"'
	localparam logic [7:0] CH_BSLASH = 8'h5C; // '\'
	localparam logic [7:0] CH_EQUAL = 8'h3D;  // '='
	localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_NAME_CHARS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_NAME_LENGTH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_VALUE_LEN = 2'd2;

	typedef struct packed {
		logic       value_valid;
		logic [7:0] value_byte;
		logic       done_res;
		logic       found;
	} result_t;

	function automatic logic [7:0] fold_case(input logic [7:0] b);
		fold_case = (b >= 8'h41 && b <= 8'h5A) ? (b + 8'd32) : b;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		is_blank = (b == CH_SPACE) || (b == CH_TAB);
	endfunction

	function automatic logic is_any_space(input logic [7:0] b);
		is_any_space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/mime_parameter_extractor_top.sv -----
// Top level of the MIME parameter extractor: config registers, parser, result register.
`default_nettype none

// Channel   | Dir | Payload                                        | Transfer when
// ----------+-----+------------------------------------------------+--------------------------
// s_*       | in  | tdata[7:0] data_byte, tlast last_byte          | s_tvalid & s_tready
// m_*       | out | tdata value_byte, tuser {found,value_valid},   | m_tvalid & m_tready
//           |     | tlast done_res                                 |
// wr_*      | in  | wr_index selects register, wr_data value       | wr_en
//
// One byte per cycle while s_tready is high: each accepted byte updates the parser state
// in the same cycle and, if it yields a result, loads the result register behind it.
// m_tvalid rises in the cycle after the input transfer of a byte that yields a result.
// s_tready drops only while a held result is stalled by m_tready low.
// arst_n clears the parser state and the result valid and loads register resets.
// A byte with tlast returns the parser to its start state for the next list.
module mime_parameter_extractor_top #(
	parameter int unsigned NAME_MAX_CHARS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  wire logic                          s_tlast,   // last_byte
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [7:0]                         m_tdata,   // [7:0] value_byte
	output logic [1:0]                         m_tuser,   // [0] value_valid, [1] found
	output logic                               m_tlast,   // done_res
	input  wire logic                          wr_en,
	input  wire logic [mpe_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [63:0]                   wr_data
);
	import mpe_pkg::*;

	logic [NAME_MAX_CHARS*8-1:0] name_chars_q;
	logic [3:0]                  name_length_q;
	logic [7:0]                  max_len_q;

	result_t result;
	logic    produce, can_take, accept;

	// Hold only the name bytes that can ever be compared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_chars_q  <= '0;
			name_length_q <= 4'd1;
			max_len_q     <= 8'd255;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_NAME_CHARS:    name_chars_q  <= wr_data[NAME_MAX_CHARS*8-1:0];
				REG_NAME_LENGTH:   name_length_q <= wr_data[3:0];
				REG_MAX_VALUE_LEN: max_len_q     <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Take a byte whenever the result register is free or draining this cycle.
	assign s_tready = can_take;
	assign accept   = s_tvalid & can_take;

	mpe_parse #(
		.NAME_MAX_CHARS(NAME_MAX_CHARS)
	) u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (accept),
		.data_byte       (s_tdata),
		.last_byte       (s_tlast),
		.name_chars      (name_chars_q),
		.name_length     (name_length_q),
		.max_value_length(max_len_q),
		.result          (result),
		.produce         (produce)
	);

	// Advance the result register only for bytes that yield a result.
	mpe_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept & produce),
		.result  (result),
		.can_take(can_take),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire

// ----- hdl/mpe_parse.sv -----
// Byte parser: split/key/value state registers and their update per accepted byte.
`default_nettype none

module mpe_parse #(
	parameter int unsigned NAME_MAX_CHARS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        last_byte,
	input  wire logic [NAME_MAX_CHARS*8-1:0] name_chars,
	input  wire logic [3:0]                  name_length,
	input  wire logic [7:0]                  max_value_length,
	output mpe_pkg::result_t                 result,
	output logic                             produce
);
	import mpe_pkg::*;

	localparam logic [2:0] PH_KEY_LEAD   = 3'd0;
	localparam logic [2:0] PH_SEG_SKIP   = 3'd1;
	localparam logic [2:0] PH_KEY_BODY   = 3'd2;
	localparam logic [2:0] PH_KEY_TAIL   = 3'd3;
	localparam logic [2:0] PH_VAL_LEAD   = 3'd4;
	localparam logic [2:0] PH_VAL_BODY   = 3'd5;
	localparam logic [2:0] PH_FINISHED   = 3'd6;
	localparam logic [2:0] PH_SEG_IGNORE = 3'd7;

	localparam logic [3:0] NAME_MAX = 4'(NAME_MAX_CHARS);

	logic       quote_open_q, split_esc_q, key_mis_q, val_quoted_q, val_esc_q, found_q;
	logic [2:0] phase_q;
	logic [3:0] key_pos_q;
	logic [7:0] val_count_q;

	logic       quote_open_d, split_esc_d, key_mis_d, val_quoted_d, val_esc_d, found_d;
	logic [2:0] phase_d;
	logic [3:0] key_pos_d;
	logic [7:0] val_count_d;
	logic       split, emit, body, kc_mis, key_match;
	logic [3:0] wanted, kc_pos;
	logic [7:0] want_ch;

	assign wanted = (name_length > NAME_MAX) ? NAME_MAX : name_length;

	// Pick the wanted name character at the current key position.
	always_comb begin
		want_ch = '0;
		for (int i = 0; i < NAME_MAX_CHARS; i++) begin
			if (key_pos_q == 4'(i)) begin
				want_ch = name_chars[i*8 +: 8];
			end
		end
	end

	assign kc_mis = (key_pos_q >= wanted) || (fold_case(data_byte) != fold_case(want_ch));
	assign kc_pos = (key_pos_q < 4'd15) ? (key_pos_q + 4'd1) : key_pos_q;
	assign key_match = !key_mis_q && (key_pos_q == wanted);

	always_comb begin
		quote_open_d = quote_open_q;
		split_esc_d  = 1'b0;
		key_mis_d    = key_mis_q;
		val_quoted_d = val_quoted_q;
		val_esc_d    = val_esc_q;
		found_d      = found_q;
		phase_d      = phase_q;
		key_pos_d    = key_pos_q;
		val_count_d  = val_count_q;
		split        = 1'b0;
		emit         = 1'b0;
		body         = 1'b0;

		// Quote-aware segment split.
		if (split_esc_q) begin
			split_esc_d = 1'b0;
		end else if (quote_open_q && data_byte == CH_BSLASH) begin
			split_esc_d = 1'b1;
		end else if (data_byte == CH_DQUOTE) begin
			quote_open_d = !quote_open_q;
		end else if (!quote_open_q && data_byte == CH_SEMI) begin
			split = 1'b1;
		end

		if (phase_q == PH_FINISHED) begin
			phase_d = PH_FINISHED;
		end else if (split) begin
			if (phase_q == PH_VAL_LEAD || phase_q == PH_VAL_BODY) begin
				phase_d = PH_FINISHED;
			end else begin
				phase_d   = PH_SEG_SKIP;
				key_pos_d = '0;
				key_mis_d = 1'b0;
			end
		end else begin
			if (phase_d == PH_SEG_SKIP && !is_any_space(data_byte)) begin
				phase_d = PH_KEY_LEAD;
			end
			if (phase_d == PH_KEY_LEAD && !is_blank(data_byte)) begin
				phase_d = PH_KEY_BODY;
			end
			unique case (phase_d)
				PH_KEY_BODY: begin
					if (data_byte == CH_EQUAL) begin
						if (key_match) begin
							found_d = 1'b1;
							phase_d = PH_VAL_LEAD;
						end else begin
							phase_d = PH_SEG_IGNORE;
						end
					end else if (is_blank(data_byte)) begin
						phase_d = PH_KEY_TAIL;
					end else begin
						key_mis_d = key_mis_q | kc_mis;
						key_pos_d = kc_pos;
					end
				end
				PH_KEY_TAIL: begin
					if (data_byte == CH_EQUAL) begin
						if (key_match) begin
							found_d = 1'b1;
							phase_d = PH_VAL_LEAD;
						end else begin
							phase_d = PH_SEG_IGNORE;
						end
					end else if (!is_blank(data_byte)) begin
						key_mis_d = 1'b1;
						key_pos_d = kc_pos;
						phase_d   = PH_KEY_BODY;
					end
				end
				PH_VAL_LEAD: begin
					if (!is_blank(data_byte)) begin
						phase_d = PH_VAL_BODY;
						if (data_byte == CH_DQUOTE) begin
							val_quoted_d = 1'b1;
						end else begin
							body = 1'b1;
						end
					end
				end
				PH_VAL_BODY: begin
					body = 1'b1;
				end
				default: begin
				end
			endcase
		end

		// Value byte handling: escapes, closing quote, ending space.
		if (body) begin
			if (val_esc_q) begin
				val_esc_d = 1'b0;
				emit      = 1'b1;
			end else if (val_quoted_d) begin
				if (data_byte == CH_DQUOTE) begin
					phase_d = PH_FINISHED;
				end else if (data_byte == CH_BSLASH) begin
					val_esc_d = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end else if (data_byte == CH_SPACE) begin
				phase_d = PH_FINISHED;
			end else begin
				emit = 1'b1;
			end
		end

		// Saturate at the configured value length.
		if (emit) begin
			if (val_count_q < max_value_length) begin
				val_count_d = val_count_q + 8'd1;
			end else begin
				emit = 1'b0;
			end
		end
	end

	assign produce            = emit | last_byte;
	assign result.value_valid = emit;
	assign result.value_byte  = emit ? data_byte : 8'd0;
	assign result.done_res    = last_byte;
	assign result.found       = last_byte & found_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_open_q <= 1'b0;
			split_esc_q  <= 1'b0;
			key_mis_q    <= 1'b0;
			val_quoted_q <= 1'b0;
			val_esc_q    <= 1'b0;
			found_q      <= 1'b0;
			phase_q      <= PH_KEY_LEAD;
			key_pos_q    <= '0;
			val_count_q  <= '0;
		end else if (advance) begin
			if (last_byte) begin
				quote_open_q <= 1'b0;
				split_esc_q  <= 1'b0;
				key_mis_q    <= 1'b0;
				val_quoted_q <= 1'b0;
				val_esc_q    <= 1'b0;
				found_q      <= 1'b0;
				phase_q      <= PH_KEY_LEAD;
				key_pos_q    <= '0;
				val_count_q  <= '0;
			end else begin
				quote_open_q <= quote_open_d;
				split_esc_q  <= split_esc_d;
				key_mis_q    <= key_mis_d;
				val_quoted_q <= val_quoted_d;
				val_esc_q    <= val_esc_d;
				found_q      <= found_d;
				phase_q      <= phase_d;
				key_pos_q    <= key_pos_d;
				val_count_q  <= val_count_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/mpe_out.sv -----
// Result register on the master side; refills while the held result drains.
`default_nettype none

module mpe_out (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire mpe_pkg::result_t result,
	output logic                  can_take,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);
	import mpe_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign can_take = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load) begin
			res_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q.value_byte;
	assign m_tuser  = {res_q.found, res_q.value_valid};
	assign m_tlast  = res_q.done_res;

endmodule

`default_nettype wire
